@@ design/bbz_pkg.sv @@
// Shared constants, codes and types of the 11x11 box blur.
package bbz_pkg;

  localparam int unsigned DefMaxWidth   = 4096;
  localparam int unsigned DefWindowSize = 11;

  localparam int unsigned CfgW     = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned PixW     = 16;
  localparam int unsigned FracBits = 8;
  localparam int unsigned NGrp     = 3;
  localparam int unsigned FifoDepth = 2;

  localparam logic [PixW-1:0] PixMask   = PixW'((33'd1 << (8 + FracBits)) - 33'd1);
  localparam logic [CfgW-1:0] ResetSize = CfgW'(2160);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef struct packed {
    logic valid;
    logic produce;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
  } result_t;

endpackage

@@ design/bbz_stream_if.sv @@
// Valid/ready stream interfaces for the pixel input and the result output.
interface bbz_in_if;
  import bbz_pkg::*;
  logic            valid;
  logic            ready;
  logic            action;
  logic [PixW-1:0] pixel_in;
  modport source (output valid, action, pixel_in, input ready);
  modport sink (input valid, action, pixel_in, output ready);
endinterface

interface bbz_out_if;
  import bbz_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_out;
  logic            last_of_frame;
  modport source (output valid, pixel_out, last_of_frame, input ready);
  modport sink (input valid, pixel_out, last_of_frame, output ready);
endinterface

@@ design/bbz_ctrl.sv @@
// Frame position counters, configuration registers and line store addressing.
module bbz_ctrl #(
  parameter int unsigned MAX_WIDTH   = bbz_pkg::DefMaxWidth,
  parameter int unsigned WINDOW_SIZE = bbz_pkg::DefWindowSize,
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
  localparam int unsigned LINES  = WINDOW_SIZE - 1,
  localparam int unsigned SLOT_W = $clog2(LINES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     in_valid_i,
  input  logic                     action_i,
  input  logic [bbz_pkg::PixW-1:0] pixel_i,
  input  logic                     cfg_we_i,
  input  logic [bbz_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bbz_pkg::CfgW-1:0] cfg_data_i,
  output logic                     rd_en_o,
  output logic [COL_W-1:0]         rd_addr_o,
  output bbz_pkg::item_ctl_t       s1_ctl_o,
  output logic [bbz_pkg::PixW-1:0] s1_pix_o,
  output logic [LINES-1:0]         s1_rowv_o,
  output logic [SLOT_W-1:0]        s1_slot_o,
  output logic [COL_W-1:0]         s1_addr_o,
  output logic [WINDOW_SIZE-1:0]   s1_colm_o
);
  import bbz_pkg::*;

  localparam int unsigned HALF  = WINDOW_SIZE / 2;
  localparam int unsigned DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W = $clog2(MAX_WIDTH + 2 * WINDOW_SIZE + 1);
  localparam int unsigned ARR_W = $clog2((MAX_WIDTH + WINDOW_SIZE) * MAX_WIDTH + WINDOW_SIZE + 1);

  logic [CfgW-1:0]   width_q, height_q;
  logic [DIM_W-1:0]  w, h;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [COL_W-1:0]  out_row_q, out_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ARR_W-1:0]  arr_q, arr_d, thr;
  logic              past_end, take, produce, last, in_wrap, out_wrap;
  logic [PixW-1:0]   pix;
  logic [LINES-1:0]  rowv;
  logic [WINDOW_SIZE-1:0] colm;
  logic [DIM_W:0]    cpos;
  item_ctl_t         s1_ctl_q;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [CfgW-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_WIDTH) begin
      r = DIM_W'(MAX_WIDTH);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  always_comb begin
    w        = clamp_dim(width_q);
    h        = clamp_dim(height_q);
    past_end = in_row_q >= ROW_W'(h);
    // A flush before the frame's last pixel is dropped without a trace.
    take     = in_valid_i && adv_i && !(action_i == ACT_FLUSH && !past_end);
    pix      = past_end ? '0 : (pixel_i & PixMask);
    thr      = ARR_W'(HALF) * ARR_W'(w) + ARR_W'(HALF);
    produce  = arr_q >= thr;
    out_wrap = out_col_q == COL_W'(w - DIM_W'(1));
    in_wrap  = in_col_q == COL_W'(w - DIM_W'(1));
    last     = produce && out_wrap && (out_row_q == COL_W'(h - DIM_W'(1)));

    for (int k = 0; k < LINES; k++) begin
      rowv[k] = (in_row_q >= ROW_W'(LINES - k)) &&
                (in_row_q < ROW_W'(h) + ROW_W'(LINES - k));
    end

    cpos = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      cpos    = (DIM_W + 1)'(out_col_q) + (DIM_W + 1)'(j);
      colm[j] = (cpos >= (DIM_W + 1)'(HALF)) &&
                ((cpos - (DIM_W + 1)'(HALF)) < {1'b0, w});
    end

    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    slot_d    = slot_q;
    arr_d     = arr_q;
    if (take) begin
      if (last) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
        slot_d    = '0;
        arr_d     = '0;
      end else begin
        arr_d = arr_q + ARR_W'(1);
        if (in_wrap) begin
          in_col_d = '0;
          in_row_d = in_row_q + ROW_W'(1);
          slot_d   = (slot_q == SLOT_W'(LINES - 1)) ? '0 : slot_q + SLOT_W'(1);
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
        if (produce) begin
          if (out_wrap) begin
            out_col_d = '0;
            out_row_d = out_row_q + COL_W'(1);
          end else begin
            out_col_d = out_col_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= ResetSize;
      height_q  <= ResetSize;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      slot_q    <= '0;
      arr_q     <= '0;
      s1_ctl_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
        // Any register write starts a new frame.
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        slot_q    <= '0;
        arr_q     <= '0;
      end else begin
        in_row_q  <= in_row_d;
        in_col_q  <= in_col_d;
        out_row_q <= out_row_d;
        out_col_q <= out_col_d;
        slot_q    <= slot_d;
        arr_q     <= arr_d;
      end
      if (adv_i) begin
        s1_ctl_q.valid   <= take;
        s1_ctl_q.produce <= take && produce;
        s1_ctl_q.last    <= last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pix_o  <= pix;
      s1_rowv_o <= rowv;
      s1_slot_o <= slot_q;
      s1_addr_o <= in_col_q;
      s1_colm_o <= colm;
    end
  end

  assign rd_en_o   = take;
  assign rd_addr_o = in_col_q;
  assign s1_ctl_o  = s1_ctl_q;

endmodule

@@ design/bbz_line_mem.sv @@
// Line store memory: read-modify-write of one pixel column per transfer.
module bbz_line_mem #(
  parameter int unsigned MAX_WIDTH   = bbz_pkg::DefMaxWidth,
  parameter int unsigned WINDOW_SIZE = bbz_pkg::DefWindowSize,
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
  localparam int unsigned LINES  = WINDOW_SIZE - 1,
  localparam int unsigned SLOT_W = $clog2(LINES),
  localparam int unsigned PART_W = $clog2(((WINDOW_SIZE + bbz_pkg::NGrp - 1) / bbz_pkg::NGrp)
                                          * (2 ** bbz_pkg::PixW - 1) + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     rd_en_i,
  input  logic [COL_W-1:0]         rd_addr_i,
  input  bbz_pkg::item_ctl_t       s1_ctl_i,
  input  logic [bbz_pkg::PixW-1:0] s1_pix_i,
  input  logic [LINES-1:0]         s1_rowv_i,
  input  logic [SLOT_W-1:0]        s1_slot_i,
  input  logic [COL_W-1:0]         s1_addr_i,
  input  logic [WINDOW_SIZE-1:0]   s1_colm_i,
  output bbz_pkg::item_ctl_t       s2_ctl_o,
  output logic [PART_W-1:0]        s2_part_o [bbz_pkg::NGrp],
  output logic [WINDOW_SIZE-1:0]   s2_colm_o
);
  import bbz_pkg::*;

  localparam int unsigned LW = LINES * PixW;

  logic [LW-1:0]     line_mem_q [MAX_WIDTH];
  logic [LW-1:0]     rdata_q, fwd_data_q, word, wdata;
  logic              fwd_hit_q, wr_en;
  logic [PixW-1:0]   wlane [LINES];
  logic [PixW-1:0]   colvec [WINDOW_SIZE];
  logic [SLOT_W:0]   lane;
  logic [PART_W-1:0] part [NGrp];
  item_ctl_t         s2_ctl_q;

  always_comb begin
    wr_en = s1_ctl_i.valid && adv_i;
    // The previous transfer may have written this column in the cycle of the read.
    word  = fwd_hit_q ? fwd_data_q : rdata_q;
    for (int l = 0; l < LINES; l++) begin
      wlane[l]               = word[l*PixW +: PixW];
      wdata[l*PixW +: PixW]  = (SLOT_W'(l) == s1_slot_i) ? s1_pix_i : word[l*PixW +: PixW];
    end
    lane = '0;
    for (int k = 0; k < LINES; k++) begin
      lane = (SLOT_W + 1)'(s1_slot_i) + (SLOT_W + 1)'(k);
      if (lane >= (SLOT_W + 1)'(LINES)) begin
        lane = lane - (SLOT_W + 1)'(LINES);
      end
      colvec[k] = s1_rowv_i[k] ? wlane[lane[SLOT_W-1:0]] : '0;
    end
    colvec[LINES] = s1_pix_i;
    for (int g = 0; g < NGrp; g++) begin
      part[g] = '0;
    end
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      part[k % NGrp] = part[k % NGrp] + PART_W'(colvec[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem_q[s1_addr_i] <= wdata;
    end
    if (rd_en_i) begin
      rdata_q    <= line_mem_q[rd_addr_i];
      fwd_data_q <= wdata;
    end
    if (adv_i) begin
      s2_part_o <= part;
      s2_colm_o <= s1_colm_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
      s2_ctl_q  <= '0;
    end else begin
      if (rd_en_i) begin
        fwd_hit_q <= wr_en && (rd_addr_i == s1_addr_i);
      end
      if (adv_i) begin
        s2_ctl_q <= s1_ctl_i;
      end
    end
  end

  assign s2_ctl_o = s2_ctl_q;

endmodule

@@ design/bbz_window.sv @@
// Window of column sums, masked total and the divide by the window area.
module bbz_window #(
  parameter int unsigned WINDOW_SIZE = bbz_pkg::DefWindowSize,
  localparam int unsigned PART_W = $clog2(((WINDOW_SIZE + bbz_pkg::NGrp - 1) / bbz_pkg::NGrp)
                                          * (2 ** bbz_pkg::PixW - 1) + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  bbz_pkg::item_ctl_t     s2_ctl_i,
  input  logic [PART_W-1:0]      s2_part_i [bbz_pkg::NGrp],
  input  logic [WINDOW_SIZE-1:0] s2_colm_i,
  output logic                   push_o,
  output bbz_pkg::result_t       push_data_o
);
  import bbz_pkg::*;

  localparam int unsigned CS_W    = $clog2(WINDOW_SIZE * (2 ** PixW - 1) + 1);
  localparam int unsigned MPART_W = $clog2(((WINDOW_SIZE + NGrp - 1) / NGrp) * WINDOW_SIZE
                                           * (2 ** PixW - 1) + 1);
  localparam int unsigned SUM_W   = $clog2(WINDOW_SIZE * WINDOW_SIZE * (2 ** PixW - 1) + 1);
  localparam int unsigned DIV     = WINDOW_SIZE * WINDOW_SIZE;
  localparam int unsigned SHIFT   = SUM_W + $clog2(DIV) + 1;
  localparam int unsigned PROD_W  = SHIFT + PixW;
  localparam longint unsigned Recip = ((64'd1 << SHIFT) / DIV) + 64'd1;

  logic [CS_W-1:0]    colsum;
  logic [CS_W-1:0]    cs_q [WINDOW_SIZE];
  logic [MPART_W-1:0] mpart [NGrp];
  logic [MPART_W-1:0] s4_part_q [NGrp];
  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   s5_sum_q;
  logic [PROD_W-1:0]  s6_prod_q;
  logic [WINDOW_SIZE-1:0] s3_colm_q;
  item_ctl_t          s3_ctl_q, s4_ctl_q, s5_ctl_q, s6_ctl_q;

  always_comb begin
    colsum = '0;
    for (int g = 0; g < NGrp; g++) begin
      colsum = colsum + CS_W'(s2_part_i[g]);
    end
    for (int g = 0; g < NGrp; g++) begin
      mpart[g] = '0;
    end
    // Columns that fall outside the frame around the centre are left out.
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if (s3_colm_q[j]) begin
        mpart[j % NGrp] = mpart[j % NGrp] + MPART_W'(cs_q[j]);
      end
    end
    total = '0;
    for (int g = 0; g < NGrp; g++) begin
      total = total + SUM_W'(s4_part_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        cs_q[j] <= '0;
      end
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
      s5_ctl_q <= '0;
      s6_ctl_q <= '0;
    end else if (adv_i) begin
      if (s2_ctl_i.valid) begin
        for (int j = 0; j + 1 < WINDOW_SIZE; j++) begin
          cs_q[j] <= cs_q[j+1];
        end
        cs_q[WINDOW_SIZE-1] <= colsum;
      end
      s3_ctl_q <= s2_ctl_i;
      s4_ctl_q <= s3_ctl_q;
      s5_ctl_q <= s4_ctl_q;
      s6_ctl_q <= s5_ctl_q;
    end
  end

  // Division by the window area is a multiply by a rounded-up reciprocal,
  // exact for every sum the window can hold.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_colm_q <= s2_colm_i;
      s4_part_q <= mpart;
      s5_sum_q  <= total;
      s6_prod_q <= PROD_W'(s5_sum_q) * PROD_W'(Recip);
    end
  end

  always_comb begin
    push_o            = s6_ctl_q.valid && s6_ctl_q.produce && adv_i;
    push_data_o.pixel = s6_prod_q[SHIFT +: PixW];
    push_data_o.last  = s6_ctl_q.last;
  end

endmodule

@@ design/bbz_out_fifo.sv @@
// Two-entry result queue between the pipeline and the output channel.
module bbz_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bbz_pkg::result_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output bbz_pkg::result_t data_o,
  output logic             space_o
);
  import bbz_pkg::*;

  localparam int unsigned CNT_W = $clog2(FifoDepth + 1);
  localparam int unsigned PTR_W = $clog2(FifoDepth);

  result_t          store_q [FifoDepth];
  logic [CNT_W-1:0] cnt_q;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic             pop;

  assign valid_o = cnt_q != '0;
  assign space_o = cnt_q != CNT_W'(FifoDepth);
  assign data_o  = store_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop);
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FifoDepth - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FifoDepth - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/box_blur_11x11_zero_pad.sv @@
// Streaming 11x11 mean filter with zero padding: one 8.8 pixel in, one window mean out, per
// clock. Each transfer reads and rewrites one column word of the line store (one memory of
// MAX_WIDTH words, each holding WINDOW_SIZE-1 pixels), so a pixel can be taken every cycle;
// a result passes through the stage registers s1 to s6 and the result queue to the port, and
// results lag their centre pixel by five rows and five pixels, so flush items drain the frame
// end. The line store needs no clearing pass after reset. Input stalls only when the two-entry
// result queue is full. A register write restarts the frame.
module box_blur_11x11_zero_pad #(
  parameter int unsigned MAX_WIDTH   = bbz_pkg::DefMaxWidth,
  parameter int unsigned WINDOW_SIZE = bbz_pkg::DefWindowSize
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bbz_in_if.sink                      in_i,
  bbz_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [bbz_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bbz_pkg::CfgW-1:0]    cfg_data_i
);
  import bbz_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LINES  = WINDOW_SIZE - 1;
  localparam int unsigned SLOT_W = $clog2(LINES);
  localparam int unsigned PART_W = $clog2(((WINDOW_SIZE + NGrp - 1) / NGrp)
                                          * (2 ** PixW - 1) + 1);

  logic                   adv, rd_en, push;
  logic [COL_W-1:0]       rd_addr, s1_addr;
  item_ctl_t              s1_ctl, s2_ctl;
  logic [PixW-1:0]        s1_pix;
  logic [LINES-1:0]       s1_rowv;
  logic [SLOT_W-1:0]      s1_slot;
  logic [WINDOW_SIZE-1:0] s1_colm, s2_colm;
  logic [PART_W-1:0]      s2_part [NGrp];
  result_t                push_data, head;

  bbz_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_i.valid),
    .action_i   (in_i.action),
    .pixel_i    (in_i.pixel_in),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .s1_ctl_o   (s1_ctl),
    .s1_pix_o   (s1_pix),
    .s1_rowv_o  (s1_rowv),
    .s1_slot_o  (s1_slot),
    .s1_addr_o  (s1_addr),
    .s1_colm_o  (s1_colm)
  );

  bbz_line_mem #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .s1_ctl_i  (s1_ctl),
    .s1_pix_i  (s1_pix),
    .s1_rowv_i (s1_rowv),
    .s1_slot_i (s1_slot),
    .s1_addr_i (s1_addr),
    .s1_colm_i (s1_colm),
    .s2_ctl_o  (s2_ctl),
    .s2_part_o (s2_part),
    .s2_colm_o (s2_colm)
  );

  bbz_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s2_ctl_i    (s2_ctl),
    .s2_part_i   (s2_part),
    .s2_colm_i   (s2_colm),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bbz_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (out_o.ready),
    .valid_o     (out_o.valid),
    .data_o      (head),
    .space_o     (adv)
  );

  assign in_i.ready          = adv;
  assign out_o.pixel_out     = head.pixel;
  assign out_o.last_of_frame = head.last;

endmodule

@@ design/bbz_checker.sv @@
// Port-level checks of the box blur and their attachment to the top level.
module bbz_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [bbz_pkg::PixW-1:0] out_pixel_i,
  input logic                     out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pixel_i) && $stable(out_last_i))
    else $error("stalled result changed");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input held off with no result waiting");

  a_ready_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |=> in_ready_i)
    else $error("input held off one cycle after an empty output");

endmodule

bind box_blur_11x11_zero_pad bbz_checker u_bbz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.pixel_out),
  .out_last_i  (out_o.last_of_frame)
);
